// File: hdl/isbe_pkg.sv
package isbe_pkg;

   localparam int STACK_DEPTH_DEF  = 16;
   localparam int LOCALS_DEPTH_DEF = 16;

   localparam logic [7:0] OP_ICONST_M1 = 8'h02;
   localparam logic [7:0] OP_ICONST_0  = 8'h03;
   localparam logic [7:0] OP_ICONST_5  = 8'h08;
   localparam logic [7:0] OP_BIPUSH    = 8'h10;
   localparam logic [7:0] OP_SIPUSH    = 8'h11;
   localparam logic [7:0] OP_ILOAD     = 8'h15;
   localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
   localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
   localparam logic [7:0] OP_ISTORE    = 8'h36;
   localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
   localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
   localparam logic [7:0] OP_IADD      = 8'h60;
   localparam logic [7:0] OP_ISUB      = 8'h64;
   localparam logic [7:0] OP_IMUL      = 8'h68;
   localparam logic [7:0] OP_IDIV      = 8'h6c;
   localparam logic [7:0] OP_IREM      = 8'h70;
   localparam logic [7:0] OP_INEG      = 8'h74;
   localparam logic [7:0] OP_IINC      = 8'h84;
   localparam logic [7:0] OP_RETURN    = 8'hb1;
   localparam logic [7:0] OP_GETSTATIC = 8'hb2;
   localparam logic [7:0] OP_INVOKE    = 8'hb6;

   localparam logic [1:0] KIND_VALUE  = 2'd0;
   localparam logic [1:0] KIND_RETURN = 2'd1;
   localparam logic [1:0] KIND_FAULT  = 2'd2;

   localparam logic [2:0] F_NONE    = 3'd0;
   localparam logic [2:0] F_OPCODE  = 3'd1;
   localparam logic [2:0] F_UNDER   = 3'd2;
   localparam logic [2:0] F_OVER    = 3'd3;
   localparam logic [2:0] F_DIVZERO = 3'd4;
   localparam logic [2:0] F_LOCAL   = 3'd5;

   typedef enum logic [3:0] {
      C_PUSH, C_LOAD, C_STORE, C_ADD, C_SUB, C_MUL, C_DIV, C_REM,
      C_NEG, C_INC, C_RET, C_NOP, C_INVOKE, C_BAD
   } cls_type;

   // classified instruction from the front part
   typedef struct packed {
      cls_type     cls;
      logic [31:0] imm;
      logic [7:0]  idx;
   } dec_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_EXEC, S_DIV, S_DONE, S_HALT
   } state_type;

endpackage

// File: hdl/isbe_if.sv
interface isbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opcode;
   logic [7:0] operand_hi;
   logic [7:0] operand_lo;
   modport source (output valid, opcode, operand_hi, operand_lo, input ready);
   modport sink (input valid, opcode, operand_hi, operand_lo, output ready);
endinterface

interface isbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic signed [31:0] value;
   logic [2:0]  fault_code;
   modport source (output valid, result_kind, value, fault_code, input ready);
   modport sink (input valid, result_kind, value, fault_code, output ready);
endinterface

// File: hdl/int_stack_bytecode_executor_core.sv
// integer bytecode executor: 2-entry instruction queue feeding an execute sequencer
// each instruction passes through the back sequencer states idle, read and execute
// results are held in the output register until taken; idiv/irem wait in the divide state for the divider
// a new instruction is taken only in the idle state, after the previous one's registered read and execute
// reset: synchronous, clears stack pointer, local valid bits and halt state
module int_stack_bytecode_executor_core #(
   parameter int STACK_DEPTH  = isbe_pkg::STACK_DEPTH_DEF,
   parameter int LOCALS_DEPTH = isbe_pkg::LOCALS_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   isbe_req_if.sink   req,
   isbe_rsp_if.source rsp
);
   import isbe_pkg::*;

   dec_type q_data;
   logic    q_valid, q_pop;

   isbe_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
   );

   isbe_back #(.STACK_DEPTH(STACK_DEPTH), .LOCALS_DEPTH(LOCALS_DEPTH)) u_back (
      .clock(clock), .reset(reset), .q_data(q_data), .q_valid(q_valid),
      .q_pop(q_pop), .rsp(rsp)
   );
endmodule

// File: hdl/isbe_front.sv
module isbe_front (
   input  logic              clock,
   input  logic              reset,
   isbe_req_if.sink          req,
   output isbe_pkg::dec_type q_data,
   output logic              q_valid,
   input  logic              q_pop
);
   import isbe_pkg::*;

   localparam int QD = 2;

   dec_type    mem_ff [QD];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   dec_type    d;
   logic       push;

   always_comb begin
      d.cls = C_BAD;
      d.imm = '0;
      d.idx = req.operand_hi;
      if (req.opcode >= OP_ICONST_M1 && req.opcode <= OP_ICONST_5) begin
         d.cls = C_PUSH;
         d.imm = {24'd0, req.opcode} - {24'd0, OP_ICONST_0};
      end else if (req.opcode == OP_BIPUSH) begin
         d.cls = C_PUSH;
         d.imm = {{24{req.operand_hi[7]}}, req.operand_hi};
      end else if (req.opcode == OP_SIPUSH) begin
         d.cls = C_PUSH;
         d.imm = {{16{req.operand_hi[7]}}, req.operand_hi, req.operand_lo};
      end else if (req.opcode == OP_ILOAD) begin
         d.cls = C_LOAD;
      end else if (req.opcode >= OP_ILOAD_0 && req.opcode <= OP_ILOAD_3) begin
         d.cls = C_LOAD;
         d.idx = req.opcode - OP_ILOAD_0;
      end else if (req.opcode == OP_ISTORE) begin
         d.cls = C_STORE;
      end else if (req.opcode >= OP_ISTORE_0 && req.opcode <= OP_ISTORE_3) begin
         d.cls = C_STORE;
         d.idx = req.opcode - OP_ISTORE_0;
      end else begin
         case (req.opcode)
            OP_IADD:      d.cls = C_ADD;
            OP_ISUB:      d.cls = C_SUB;
            OP_IMUL:      d.cls = C_MUL;
            OP_IDIV:      d.cls = C_DIV;
            OP_IREM:      d.cls = C_REM;
            OP_INEG:      d.cls = C_NEG;
            OP_IINC: begin
               d.cls = C_INC;
               d.imm = {{24{req.operand_lo[7]}}, req.operand_lo};
            end
            OP_RETURN:    d.cls = C_RET;
            OP_GETSTATIC: d.cls = C_NOP;
            OP_INVOKE:    d.cls = C_INVOKE;
            default:      d.cls = C_BAD;
         endcase
      end
   end

   assign req.ready = (cnt_ff != 2'(QD));
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= d;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end
endmodule

// File: hdl/isbe_div.sv
module isbe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [31:0] quot,
   output logic [31:0] rem
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff;
   logic [5:0]  n_ff;
   logic        na_ff, nq_ff, busy_ff;
   logic [32:0] t;

   // restoring division on magnitudes, one bit a cycle
   always_comb begin
      t = {r_ff, q_ff[31]} - {1'b0, d_ff};
      if (!t[32]) begin
         r_in = t[31:0];
         q_in = {q_ff[30:0], 1'b1};
      end else begin
         r_in = {r_ff[30:0], q_ff[31]};
         q_in = {q_ff[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= a[31] ? (32'd0 - a) : a;
         d_ff <= b[31] ? (32'd0 - b) : b;
         r_ff <= '0;
         na_ff <= a[31];
         nq_ff <= a[31] ^ b[31];
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         n_ff <= 6'd32;
      end else if (busy_ff) begin
         n_ff <= n_ff - 6'd1;
         if (n_ff == 6'd1) busy_ff <= 1'b0;
      end
   end

   assign done = busy_ff && (n_ff == 6'd1);
   assign quot = nq_ff ? (32'd0 - q_in) : q_in;
   assign rem  = na_ff ? (32'd0 - r_in) : r_in;
endmodule

// File: hdl/isbe_back.sv
module isbe_back #(
   parameter int STACK_DEPTH  = isbe_pkg::STACK_DEPTH_DEF,
   parameter int LOCALS_DEPTH = isbe_pkg::LOCALS_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  isbe_pkg::dec_type q_data,
   input  logic              q_valid,
   output logic              q_pop,
   isbe_rsp_if.source        rsp
);
   import isbe_pkg::*;

   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LAW = (LOCALS_DEPTH > 1) ? $clog2(LOCALS_DEPTH) : 1;

   logic [31:0] stk_mem [STACK_DEPTH];
   logic [31:0] loc_mem [LOCALS_DEPTH];
   logic [LOCALS_DEPTH-1:0] lvalid_ff;

   state_type   st_ff, st_in;
   dec_type     cur_ff;
   logic [SPW-1:0] sp_ff;
   logic [31:0] ra_ff, rb_ff, rl_ff;
   logic        lv_ff;
   logic [1:0]  kind_ff;
   logic [31:0] val_ff;
   logic [2:0]  code_ff;

   logic        need1, need2, is_push, uses_loc, loc_bad, under, over;
   logic [SAW-1:0] a1, a2;
   logic [LAW-1:0] li;
   logic [31:0] locv, res;
   logic        div_start, div_done;
   logic [31:0] dq, dr;

   // exec outcome
   logic        s_wr, l_wr, emit_en;
   logic [SAW-1:0] s_addr;
   logic [31:0] s_data, l_data;
   logic [SPW-1:0] sp_new;
   logic [1:0]  e_kind;
   logic [31:0] e_val;
   logic [2:0]  e_code;

   assign need1 = cur_ff.cls == C_STORE || cur_ff.cls == C_NEG
      || cur_ff.cls == C_INVOKE;
   assign need2 = cur_ff.cls == C_ADD || cur_ff.cls == C_SUB || cur_ff.cls == C_MUL
      || cur_ff.cls == C_DIV || cur_ff.cls == C_REM;
   assign is_push = cur_ff.cls == C_PUSH || cur_ff.cls == C_LOAD;
   assign uses_loc = cur_ff.cls == C_LOAD || cur_ff.cls == C_STORE
      || cur_ff.cls == C_INC;
   assign loc_bad = {24'd0, cur_ff.idx} >= 32'(LOCALS_DEPTH);
   assign under = (need1 && sp_ff < SPW'(1)) || (need2 && sp_ff < SPW'(2));
   assign over = is_push && (sp_ff == SPW'(STACK_DEPTH));
   assign a1 = SAW'(sp_ff - SPW'(1));
   assign a2 = SAW'(sp_ff - SPW'(2));
   assign li = LAW'(cur_ff.idx);
   assign locv = lv_ff ? rl_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (st_ff == S_RD) begin
         rb_ff <= stk_mem[a1];
         ra_ff <= stk_mem[a2];
         rl_ff <= loc_mem[li];
         lv_ff <= lvalid_ff[li];
      end
   end

   always_comb begin
      case (cur_ff.cls)
         C_ADD:   res = ra_ff + rb_ff;
         C_SUB:   res = ra_ff - rb_ff;
         C_MUL:   res = ra_ff * rb_ff;
         C_DIV:   res = dq;
         C_REM:   res = dr;
         default: res = 32'd0;
      endcase
   end

   isbe_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .a(ra_ff), .b(rb_ff),
      .done(div_done), .quot(dq), .rem(dr)
   );

   always_comb begin
      s_wr = 1'b0; l_wr = 1'b0; emit_en = 1'b0;
      s_addr = a1; s_data = res; l_data = rb_ff; sp_new = sp_ff;
      e_kind = KIND_FAULT; e_val = 32'd0; e_code = F_NONE;
      div_start = 1'b0;
      if (st_ff == S_EXEC) begin
         if (cur_ff.cls == C_BAD) begin
            emit_en = 1'b1; e_code = F_OPCODE;
         end else if (under) begin
            emit_en = 1'b1; e_code = F_UNDER;
         end else if (over) begin
            emit_en = 1'b1; e_code = F_OVER;
         end else if (uses_loc && loc_bad) begin
            emit_en = 1'b1; e_code = F_LOCAL;
         end else begin
            case (cur_ff.cls)
               C_PUSH: begin
                  s_wr = 1'b1; s_addr = SAW'(sp_ff); s_data = cur_ff.imm;
                  sp_new = sp_ff + SPW'(1);
               end
               C_LOAD: begin
                  s_wr = 1'b1; s_addr = SAW'(sp_ff); s_data = locv;
                  sp_new = sp_ff + SPW'(1);
               end
               C_STORE: begin
                  l_wr = 1'b1; sp_new = sp_ff - SPW'(1);
               end
               C_INC: begin
                  l_wr = 1'b1; l_data = locv + cur_ff.imm;
               end
               C_ADD, C_SUB, C_MUL: begin
                  s_wr = 1'b1; s_addr = a2; sp_new = sp_ff - SPW'(1);
               end
               C_DIV, C_REM: begin
                  if (rb_ff == 32'd0) begin
                     emit_en = 1'b1; e_code = F_DIVZERO;
                  end else begin
                     div_start = 1'b1;
                  end
               end
               C_NEG: begin
                  s_wr = 1'b1; s_data = 32'd0 - rb_ff;
               end
               C_RET: begin
                  emit_en = 1'b1; e_kind = KIND_RETURN;
               end
               C_INVOKE: begin
                  emit_en = 1'b1; e_kind = KIND_VALUE; e_val = rb_ff;
                  sp_new = sp_ff - SPW'(1);
               end
               default: ;
            endcase
         end
      end else if (st_ff == S_DIV && div_done) begin
         s_wr = 1'b1; s_addr = a2; sp_new = sp_ff - SPW'(1);
      end
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (q_valid) st_in = S_RD;
         S_RD:   st_in = S_EXEC;
         S_EXEC: begin
            if (emit_en) st_in = S_DONE;
            else if (div_start) st_in = S_DIV;
            else st_in = S_IDLE;
         end
         S_DIV:  if (div_done) st_in = S_IDLE;
         S_DONE: begin
            if (rsp.ready) st_in = (kind_ff == KIND_VALUE) ? S_IDLE : S_HALT;
         end
         S_HALT: st_in = S_HALT;
         default: st_in = S_IDLE;
      endcase
   end

   // halted: keep draining the queue and drop items
   assign q_pop = q_valid && (st_ff == S_IDLE || st_ff == S_HALT);
   assign rsp.valid = st_ff == S_DONE;
   assign rsp.result_kind = kind_ff;
   assign rsp.value = val_ff;
   assign rsp.fault_code = code_ff;

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && q_valid) cur_ff <= q_data;
      if (s_wr) stk_mem[s_addr] <= s_data;
      if (l_wr) loc_mem[li] <= l_data;
      if (emit_en) begin
         kind_ff <= e_kind;
         val_ff <= e_val;
         code_ff <= e_code;
      end
      if (reset) begin
         st_ff <= S_IDLE;
         sp_ff <= '0;
         lvalid_ff <= '0;
      end else begin
         st_ff <= st_in;
         sp_ff <= sp_new;
         if (l_wr) lvalid_ff[li] <= 1'b1;
      end
   end
endmodule
